>>> hdl/dictionary_cam_with_aging_lru_defines.svh
`ifndef DICTIONARY_CAM_WITH_AGING_LRU_DEFINES_SVH
`define DICTIONARY_CAM_WITH_AGING_LRU_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DCAM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcam: same-cycle property failed");

// next-cycle implication, quiet during reset
`define DCAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcam: next-cycle property failed");

`endif

>>> hdl/dcam_pkg.sv
package dcam_pkg;

  localparam int DATA_W      = 64;
  localparam int IDX_W       = 4;
  localparam int DIFF_W      = 8;
  localparam int THR_W       = 7;
  localparam int AGE_W       = 8;
  localparam int ENTRIES_DEF = 16;

  localparam logic [THR_W-1:0] THR_RESET = 7'd16;
  localparam logic [AGE_W-1:0] AGE_TOP   = 8'h80;
  localparam logic [AGE_W-1:0] AGE_FULL  = 8'hff;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_EXACT = 3'd2,
    OP_NEAR  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

endpackage

>>> hdl/dictionary_cam_with_aging_lru.sv
// Dictionary store of ENTRIES 64-bit words with an 8-bit age per entry. Each
// request beat carries an operation: read or write one entry by index, exact
// search (last equal entry), nearest search (first entry whose signed
// difference from the word has the strictly smallest magnitude below
// nearest_threshold, then overwritten with the word), or clear. A search miss
// replaces the entry with the lowest age (lowest index on ties); every search
// then shifts all ages right and sets bit 7 of the chosen entry (a replaced
// entry restarts at 8'h80). Exactly one result beat follows each request
// beat. Write, clear and unused codes go from accept straight to S_DONE, a
// read through S_RD and a search through S_SCAN and S_FIN; the scan uses the
// single read port of the word memory, one entry per cycle, with one shared
// compare unit doing the equality, difference and age checks. in_ready is low
// while a request is in progress; a finished result may wait in the output
// register while the next request is taken. The threshold write channel is
// always ready and is meant to be used while no request is in progress.
module dictionary_cam_with_aging_lru #(
  parameter int ENTRIES = dcam_pkg::ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dcam_pkg::THR_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [2:0]                             func,
  input  logic [dcam_pkg::IDX_W-1:0]             entry_index,
  input  logic [dcam_pkg::DATA_W-1:0]            data_word,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   found,
  output logic [dcam_pkg::IDX_W-1:0]             result_index,
  output logic signed [dcam_pkg::DIFF_W-1:0]     difference,
  output logic [dcam_pkg::DATA_W-1:0]            read_data
);
  import dcam_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_SCAN = 5'b00100,
    S_FIN  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [THR_W-1:0]  thresh;
  logic [DATA_W-1:0] word_mem [ENTRIES];
  logic [DATA_W-1:0] mem_q;
  logic              entry_vld [ENTRIES];
  logic [AGE_W-1:0]  age [ENTRIES];

  logic [2:0]        op_q;
  logic [DATA_W-1:0] w_q;
  logic [IW-1:0]     idx_q;
  logic              idx_ok_q;

  logic [CW-1:0]     scan_cnt;
  logic              cmp_vld;
  logic [IW-1:0]     cmp_idx;

  logic              ex_got, nr_got;
  logic [IW-1:0]     ex_slot, nr_slot, old_slot;
  logic [THR_W-1:0]  best_mag;
  logic [DIFF_W-1:0] best_diff;
  logic [AGE_W-1:0]  low_age;

  logic                     p_found;
  logic [IDX_W-1:0]         p_ridx;
  logic signed [DIFF_W-1:0] p_diff;
  logic [DATA_W-1:0]        p_rdata;

  logic              accept, idx_ok, out_free;
  logic              rd_en, wr_en;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] entry_val, d;
  logic [THR_W-1:0]  mag;
  logic              small_pos, small_neg, nr_hit;
  logic [AGE_W-1:0]  age_k;
  logic              is_near, got_fin;
  logic [IW-1:0]     slot_fin;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign idx_ok    = ({5'b0, entry_index} < 9'(ENTRIES));
  assign out_free  = !out_valid || out_ready;

  // shared compare unit, one entry per cycle
  assign entry_val = entry_vld[cmp_idx] ? mem_q : '0;
  assign d         = entry_val - w_q;
  assign small_pos = ~|d[DATA_W-1:THR_W];
  assign small_neg = (&d[DATA_W-1:THR_W]) && (|d[THR_W-1:0]);
  assign mag       = d[DATA_W-1] ? (~d[THR_W-1:0] + 7'd1) : d[THR_W-1:0];
  assign nr_hit    = (small_pos || small_neg) && (mag < best_mag);
  assign age_k     = age[cmp_idx];

  assign is_near  = (op_q == OP_NEAR);
  assign got_fin  = is_near ? nr_got : ex_got;
  assign slot_fin = !got_fin ? old_slot : (is_near ? nr_slot : ex_slot);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_cnt[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = IW'(entry_index);
    wr_data = data_word;
    case (state)
      S_IDLE: begin
        rd_addr = IW'(entry_index);
        rd_en   = accept && (func == OP_READ) && idx_ok;
        wr_en   = accept && (func == OP_WRITE) && idx_ok;
      end
      S_SCAN: begin
        rd_en = (scan_cnt != CW'(ENTRIES));
      end
      S_FIN: begin
        wr_en   = is_near || !got_fin;
        wr_addr = slot_fin;
        wr_data = w_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func)
            OP_READ:  state_next = S_RD;
            OP_EXACT: state_next = S_SCAN;
            OP_NEAR:  state_next = S_SCAN;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_RD:   state_next = S_DONE;
      S_SCAN: if (scan_cnt == CW'(ENTRIES) && !cmp_vld) state_next = S_FIN;
      S_FIN:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= word_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENTRIES; k++) entry_vld[k] <= 1'b0;
    end else if (accept && func == OP_CLEAR) begin
      for (int k = 0; k < ENTRIES; k++) entry_vld[k] <= 1'b0;
    end else if (wr_en) begin
      entry_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENTRIES; k++) age[k] <= '0;
    end else if (accept && func == OP_CLEAR) begin
      for (int k = 0; k < ENTRIES; k++) age[k] <= '0;
    end else if (state == S_FIN) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (IW'(k) == slot_fin) begin
          age[k] <= got_fin ? ((age[k] >> 1) | AGE_TOP) : AGE_TOP;
        end else begin
          age[k] <= age[k] >> 1;
        end
      end
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      cmp_vld  <= 1'b0;
    end else if (accept) begin
      scan_cnt <= '0;
      cmp_vld  <= 1'b0;
    end else if (state == S_SCAN) begin
      if (scan_cnt != CW'(ENTRIES)) begin
        scan_cnt <= scan_cnt + 1'b1;
        cmp_vld  <= 1'b1;
      end else begin
        cmp_vld  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      cmp_idx <= scan_cnt[IW-1:0];
    end
  end

  // request latch and running search bests
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= func;
      w_q       <= data_word;
      idx_q     <= IW'(entry_index);
      idx_ok_q  <= idx_ok;
      ex_got    <= 1'b0;
      nr_got    <= 1'b0;
      ex_slot   <= '0;
      nr_slot   <= '0;
      old_slot  <= '0;
      best_mag  <= thresh;
      best_diff <= {1'b0, thresh};
      low_age   <= AGE_FULL;
    end else if (state == S_SCAN && cmp_vld) begin
      if (entry_val == w_q) begin
        ex_got  <= 1'b1;
        ex_slot <= cmp_idx;
      end
      if (nr_hit) begin
        nr_got    <= 1'b1;
        nr_slot   <= cmp_idx;
        best_mag  <= mag;
        best_diff <= d[DIFF_W-1:0];
      end
      if (age_k < low_age) begin
        low_age  <= age_k;
        old_slot <= cmp_idx;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      p_found <= 1'b0;
      p_ridx  <= '0;
      p_diff  <= '0;
      p_rdata <= '0;
    end else if (state == S_RD) begin
      p_rdata <= (idx_ok_q && entry_vld[idx_q]) ? mem_q : '0;
    end else if (state == S_FIN) begin
      p_found <= got_fin;
      p_ridx  <= IDX_W'(slot_fin);
      p_diff  <= is_near ? $signed(best_diff) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      found        <= p_found;
      result_index <= p_ridx;
      difference   <= p_diff;
      read_data    <= p_rdata;
    end
  end

endmodule

>>> hdl/dcam_checker.sv
`include "dictionary_cam_with_aging_lru_defines.svh"

module dcam_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               found,
  input logic [dcam_pkg::IDX_W-1:0]         result_index,
  input logic signed [dcam_pkg::DIFF_W-1:0] difference,
  input logic [dcam_pkg::DATA_W-1:0]        read_data
);
  import dcam_pkg::*;

  localparam logic signed [DIFF_W-1:0] DIFF_MIN = {1'b1, {(DIFF_W-1){1'b0}}};

  // a taken request keeps the block busy in the next cycle
  `DCAM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a stalled result beat holds
  `DCAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(found) && $stable(result_index) &&
    $stable(difference) && $stable(read_data))

  // only a read returns data, and a read reports nothing else
  `DCAM_ASSERT_NOW(a_read_only_data, out_valid && read_data != '0,
    !found && result_index == '0 && difference == '0)

  // a hit never carries the most negative difference
  `DCAM_ASSERT_NOW(a_hit_diff_range, out_valid && found, difference != DIFF_MIN)

endmodule

bind dictionary_cam_with_aging_lru dcam_checker u_dcam_checker (.*);

>>> tb/sv/dictionary_cam_with_aging_lru_tb.sv
`timescale 1ns / 1ps

module dictionary_cam_with_aging_lru_tb;
  import dcam_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MSB = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    BEAT_REQ,
    BEAT_CFG,
    BEAT_DRAIN
  } beat_kind_t;

  typedef struct {
    beat_kind_t        kind;
    logic [2:0]        func;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] word;
    logic [THR_W-1:0]  thr;
    int unsigned       pause_pct;
  } beat_t;

  typedef struct packed {
    logic                     found;
    logic [IDX_W-1:0]         idx;
    logic signed [DIFF_W-1:0] diff;
    logic [DATA_W-1:0]        rdata;
  } cam_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [THR_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               func = '0;
  logic [IDX_W-1:0]         entry_index = '0;
  logic [DATA_W-1:0]        data_word = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     found;
  logic [IDX_W-1:0]         result_index;
  logic signed [DIFF_W-1:0] difference;
  logic [DATA_W-1:0]        read_data;

  // model of the table, the ages and the threshold
  logic [DATA_W-1:0] dict_words [ENTRIES_DEF];
  logic [AGE_W-1:0]  dict_ages [ENTRIES_DEF];
  logic [THR_W-1:0]  thr_model;

  beat_t       beats_to_send [$];
  cam_result_t results_due [$];
  int          beats_in;
  int          beats_out;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned stall_pct = 0;
  bit          fail_seen = 1'b0;
  int unsigned gen_pause = 0;

  dictionary_cam_with_aging_lru i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .entry_index  (entry_index),
    .data_word    (data_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .result_index (result_index),
    .difference   (difference),
    .read_data    (read_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic queue_req(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] word);
    beats_to_send.push_back('{kind: BEAT_REQ, func: op, idx: idx, word: word,
                              thr: '0, pause_pct: gen_pause});
  endtask

  task automatic queue_cfg(input logic [THR_W-1:0] thr);
    beats_to_send.push_back('{kind: BEAT_CFG, func: '0, idx: '0, word: '0,
                              thr: thr, pause_pct: gen_pause});
  endtask

  task automatic queue_drain();
    beats_to_send.push_back('{kind: BEAT_DRAIN, func: '0, idx: '0, word: '0,
                              thr: '0, pause_pct: gen_pause});
  endtask

  // updates the model for one request beat and records the result it owes
  task automatic lookup_and_age(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] word);
    cam_result_t      r;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] best_mag;
    logic [AGE_W-1:0]  low_age;
    int                slot;
    logic              hit;
    r = '0;
    slot = 0;
    hit = 1'b0;
    case (op)
      OP_READ: r.rdata = dict_words[idx];
      OP_WRITE: dict_words[idx] = word;
      OP_EXACT, OP_NEAR: begin
        best_mag = thr_model;
        if (op == OP_NEAR) r.diff = thr_model;
        for (int k = 0; k < ENTRIES_DEF; k++) begin
          if (op == OP_EXACT) begin
            if (dict_words[k] == word) begin
              hit = 1'b1;
              slot = k;
            end
          end else begin
            d = dict_words[k] - word;
            mag = d[DATA_W-1] ? (64'd0 - d) : d;
            if (mag < best_mag) begin
              hit = 1'b1;
              best_mag = mag;
              r.diff = d[DIFF_W-1:0];
              slot = k;
            end
          end
        end
        if (hit && op == OP_NEAR) dict_words[slot] = word;
        if (!hit) begin
          // replace the least recently used entry
          low_age = AGE_FULL;
          slot = 0;
          for (int k = 0; k < ENTRIES_DEF; k++) begin
            if (dict_ages[k] < low_age) begin
              low_age = dict_ages[k];
              slot = k;
            end
          end
          dict_words[slot] = word;
          dict_ages[slot] = '0;
        end
        for (int k = 0; k < ENTRIES_DEF; k++) dict_ages[k] = dict_ages[k] >> 1;
        dict_ages[slot] = dict_ages[slot] | AGE_TOP;
        r.found = hit;
        r.idx = slot[IDX_W-1:0];
      end
      OP_CLEAR: begin
        for (int k = 0; k < ENTRIES_DEF; k++) begin
          dict_words[k] = '0;
          dict_ages[k] = '0;
        end
      end
      default: ;
    endcase
    results_due.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    beat_t b;
    logic  hold_req;
    logic  hold_cfg;
    logic  go_req;
    logic  go_cfg;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      beats_in = 0;
      thr_model = THR_RESET;
      for (int k = 0; k < ENTRIES_DEF; k++) begin
        dict_words[k] = '0;
        dict_ages[k] = '0;
      end
    end else begin
      hold_req = in_valid && !in_ready;
      hold_cfg = cfg_valid && !cfg_ready;
      go_req = hold_req;
      go_cfg = hold_cfg;
      if (in_valid && in_ready) begin
        lookup_and_age(func, entry_index, data_word);
        beats_in++;
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
          gap_left = $urandom_range(1, 6);
      end
      if (cfg_valid && cfg_ready) thr_model = cfg_data;
      if (!hold_req && !hold_cfg) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (beats_to_send.size() != 0) begin
          b = beats_to_send[0];
          case (b.kind)
            BEAT_REQ: begin
              go_req = 1'b1;
              func <= b.func;
              entry_index <= b.idx;
              data_word <= b.word;
              stall_pct <= b.pause_pct;
              void'(beats_to_send.pop_front());
            end
            BEAT_CFG: begin
              if (beats_in == beats_out) begin
                go_cfg = 1'b1;
                cfg_data <= b.thr;
                void'(beats_to_send.pop_front());
              end
            end
            default: begin
              if (beats_in == beats_out) void'(beats_to_send.pop_front());
            end
          endcase
        end
      end
      in_valid <= go_req;
      cfg_valid <= go_cfg;
    end
  end

  // result monitor
  always @(posedge clk) begin
    cam_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      beats_out <= 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out <= beats_out + 1;
        if (results_due.size() == 0) begin
          $display("%0t: result beat with none expected, actual index %0d", $time,
                   result_index);
          fail_seen = 1'b1;
        end else begin
          want = results_due.pop_front();
          if (found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            fail_seen = 1'b1;
          end
          if (result_index !== want.idx) begin
            $display("%0t: result_index expected %0d actual %0d", $time, want.idx,
                     result_index);
            fail_seen = 1'b1;
          end
          if (difference !== want.diff) begin
            $display("%0t: difference expected %0d actual %0d", $time, want.diff,
                     difference);
            fail_seen = 1'b1;
          end
          if (read_data !== want.rdata) begin
            $display("%0t: read_data expected %h actual %h", $time, want.rdata,
                     read_data);
            fail_seen = 1'b1;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0]       w;
    logic [DATA_W-1:0]       base;
    logic signed [DATA_W-1:0] off64;
    logic [THR_W-1:0]        gen_thr;
    logic [IDX_W-1:0]        idx;
    logic [DATA_W-1:0]       word_pool [$];
    int unsigned             pause_menu [4];
    int unsigned             sel;
    int                      off;
    bit                      keep;
    pause_menu = '{0, 10, 25, 50};
    gen_thr = THR_RESET;
    word_pool.push_back('0);

    // directed part
    queue_req(OP_READ, 4'd0, '0);
    queue_req(OP_WRITE, 4'd0, '1);
    queue_req(OP_WRITE, 4'd15, WORD_MSB);
    queue_req(OP_READ, 4'd15, '0);
    queue_req(OP_READ, 4'd0, '1);
    queue_req(OP_EXACT, 4'd0, '1);
    queue_req(OP_EXACT, 4'd15, '0);
    queue_req(OP_EXACT, 4'd0, 64'h0123_4567_89ab_cdef);
    queue_req(OP_NEAR, 4'd0, 64'h7fff_ffff_ffff_ffff);
    queue_req(OP_WRITE, 4'd5, 64'h1000);
    queue_req(OP_NEAR, 4'd0, 64'h100f);
    queue_req(OP_NEAR, 4'd0, 64'h101f);
    queue_req(OP_NEAR, 4'd0, 64'hffff_ffff_ffff_fff2);
    queue_req(OP_CLEAR, 4'd9, '1);
    // every difference is the most negative value
    queue_req(OP_NEAR, 4'd3, WORD_MSB);
    queue_req(OP_SPARE_LO, 4'd15, '1);
    queue_req(OP_SPARE_HI, 4'd0, '0);
    queue_cfg('0);
    queue_req(OP_NEAR, 4'd0, '0);
    queue_cfg('1);
    queue_req(OP_NEAR, 4'd0, 64'd126);
    queue_req(OP_NEAR, 4'd0, 64'hffff_ffff_ffff_ff82);
    queue_req(OP_NEAR, 4'd0, 64'd254);
    queue_cfg(THR_RESET);

    // random part in phases, each with its own threshold and idling
    for (int p = 0; p < 11; p++) begin
      if (p > 0) begin
        case (p)
          1: gen_thr = 7'd127;
          2: gen_thr = 7'd0;
          3: gen_thr = 7'd1;
          default: gen_thr = 7'($urandom_range(0, 127));
        endcase
        queue_cfg(gen_thr);
      end
      gen_pause = (p == 10) ? 0 : pause_menu[$urandom_range(0, 3)];
      for (int n = 0; n < 150; n++) begin
        if (n == 75 && p != 10) queue_drain();
        sel = $urandom_range(0, 99);
        idx = 4'($urandom_range(0, 15));
        base = word_pool[$urandom_range(0, word_pool.size() - 1)];
        off = int'($urandom_range(0, 2 * gen_thr + 8)) - int'(gen_thr) - 4;
        off64 = off;
        keep = 1'b1;
        w = {$urandom, $urandom};
        if (sel < 14) begin
          keep = 1'b0;
          queue_req(OP_READ, idx, w);
        end else if (sel < 32) begin
          if ($urandom_range(0, 1) == 0) w = base + off64;
          queue_req(OP_WRITE, idx, w);
        end else if (sel < 57) begin
          if ($urandom_range(0, 3) != 0) w = base;
          queue_req(OP_EXACT, idx, w);
        end else if (sel < 96) begin
          case ($urandom_range(0, 9))
            0: ;
            1: w = base ^ WORD_MSB;
            default: w = base + off64;
          endcase
          queue_req(OP_NEAR, idx, w);
        end else if (sel < 97) begin
          keep = 1'b0;
          queue_req(OP_CLEAR, idx, w);
        end else begin
          keep = 1'b0;
          queue_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), idx, w);
        end
        if (keep) begin
          word_pool.push_back(w);
          if (word_pool.size() > 24) void'(word_pool.pop_front());
        end
      end
    end

    while (beats_to_send.size() != 0 || in_valid || cfg_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (ENTRIES_DEF + 8) @(posedge clk);
    if (!fail_seen && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
